[rtl/core/sblm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblm_pkg
// Shared sizes, register codes, tables and types of the band level meter.
// ----------------------------------------------------------------------------
package sblm_pkg;

  // block sizing
  localparam int BANDS       = 32;
  localparam int FFT_BINS    = 2048;
  localparam int ATTEN_START = 21;
  localparam int MAG_WIDTH   = 24;

  // field widths
  localparam int EDGE_W     = 12;
  localparam int SLOT_W     = 6;
  localparam int BAND_W     = 5;
  localparam int LEVEL_W    = 16;
  localparam int FLOOR_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int KEEP_W     = 9;
  localparam int DEPTH_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // derived widths
  localparam int CB_W    = $clog2(BANDS + 1);
  localparam int EA_W    = $clog2(BANDS + 1);
  localparam int SM_AW   = $clog2(BANDS);
  localparam int CNT_W   = $clog2(FFT_BINS + 1);
  localparam int CMP_W   = (CNT_W > EDGE_W) ? CNT_W : EDGE_W;
  localparam int P_W     = $clog2(MAG_WIDTH);
  localparam int L2_W    = $clog2(MAG_WIDTH - 8) + 8;
  localparam int DB_W    = L2_W + 3;
  localparam int DIFF_W  = (DB_W > FLOOR_W) ? DB_W : FLOOR_W;
  localparam int PA_W    = DEPTH_W + BAND_W;
  localparam int FAC_W   = LEVEL_W + 1;
  localparam int SMP_W   = KEEP_W + LEVEL_W;

  // 20*log10(2) in Q8
  localparam int DB_MUL = 1541;

  // attenuation slope divider as reciprocal multiply, exact for all inputs
  localparam int ATT_ON    = (BANDS > ATTEN_START) ? 1 : 0;
  localparam int ATT_DIV   = (BANDS > ATTEN_START) ? (BANDS - ATTEN_START) : 1;
  localparam int RECIP_SH  = 27;
  localparam int RECIP_W   = 28;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SH) + longint'(ATT_DIV) - 1) / longint'(ATT_DIV));
  localparam logic [FAC_W-1:0] FAC_ONE = FAC_W'(1) << LEVEL_W;

  // input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BIN  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = CFG_IDX_W'(3);

  // register reset values
  localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(2560);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(1872);
  localparam logic [KEEP_W-1:0]  KEEP_RST  = KEEP_W'(192);
  localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(26214);

  // round(256*log2(1+k/32))
  localparam logic [7:0] LOG2_FRAC [32] = '{
    8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
    8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
    8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
    8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
  };

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_q8;
    logic [GAIN_W-1:0]  gain_q16;
    logic [DEPTH_W-1:0] depth_q16;
  } lvl_cfg_t;

endpackage

[rtl/core/sblm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblm channel interfaces
// Bin/edge input channel, band result channel and register write channel.
// ----------------------------------------------------------------------------
interface sblm_item_if import sblm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] edge_slot;
  logic [EDGE_W-1:0] edge_bin;
  logic [MAG_WIDTH-1:0] magnitude;
  logic              last_bin;

  modport source (output valid, mode, edge_slot, edge_bin, magnitude, last_bin,
                  input ready);
  modport sink   (input valid, mode, edge_slot, edge_bin, magnitude, last_bin,
                  output ready);
endinterface

interface sblm_result_if import sblm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BAND_W-1:0]  band;
  logic [LEVEL_W-1:0] level;
  logic               last_band;

  modport source (output valid, band, level, last_band, input ready);
  modport sink   (input valid, band, level, last_band, output ready);
endinterface

interface sblm_cfg_if import sblm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/sblm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblm_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sblm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/sblm_level.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblm_level
// Seven-stage pipeline from band peak magnitude to attenuated 0..1 level:
// log2 by leading one and table, dB scale, floor and gain, band attenuation.
// ----------------------------------------------------------------------------
module sblm_level import sblm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MAG_WIDTH-1:0] mag,
  input  logic [BAND_W-1:0]    band,
  input  lvl_cfg_t             cfg,
  output logic                 done,
  output logic [LEVEL_W-1:0]   level
);

  logic [6:0] vld;

  // stage 1: leading one
  logic [P_W-1:0]       lead;
  logic [P_W-1:0]       r1_p;
  logic [MAG_WIDTH-1:0] r1_mag;
  logic                 r1_small;
  logic [BAND_W-1:0]    r1_band;

  // stage 2: log2 in Q8
  logic [MAG_WIDTH-1:0] shifted;
  logic [4:0]           frac_idx;
  logic [L2_W-1:0]      l2;
  logic [L2_W-1:0]      r2_l2;
  logic                 r2_small;
  logic [BAND_W-1:0]    r2_band;

  // stage 3: decibels
  logic [L2_W+10:0]     prod_db;
  logic [DB_W-1:0]      r3_db;
  logic                 r3_small;
  logic [BAND_W-1:0]    r3_band;

  // stage 4: floor and gain
  logic                        above;
  logic [DIFF_W-1:0]           diff;
  logic [DIFF_W+GAIN_W-1:0]    prod_g;
  logic [LEVEL_W-1:0]          lvl_g;
  logic [LEVEL_W-1:0]          r4_lvl;
  logic [BAND_W-1:0]           r4_band;

  // stage 5: attenuation product
  logic                 att_on;
  logic [BAND_W-1:0]    att_d;
  logic [PA_W-1:0]      r5_prod;
  logic [LEVEL_W-1:0]   r5_lvl;

  // stage 6: divide by slope span, factor
  logic [PA_W+RECIP_W-1:0] prod_r;
  logic [PA_W+RECIP_W-RECIP_SH-1:0] drop;
  logic [FAC_W-1:0]     fac;
  logic [FAC_W-1:0]     r6_fac;
  logic [LEVEL_W-1:0]   r6_lvl;

  // stage 7: apply factor
  logic [LEVEL_W+FAC_W-1:0] prod_f;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_WIDTH; i++) begin
      if (mag[i]) begin
        lead = P_W'(i);
      end
    end
  end

  // index bits are the five below the leading one
  assign shifted  = r1_mag >> (r1_p - P_W'(5));
  assign frac_idx = shifted[4:0];
  assign l2       = {(L2_W-8)'(r1_p - P_W'(8)), LOG2_FRAC[frac_idx]};

  assign prod_db = (L2_W+11)'(r2_l2) * (L2_W+11)'(DB_MUL);

  assign above  = !r3_small && (DIFF_W'(r3_db) > DIFF_W'(cfg.floor_q8));
  assign diff   = DIFF_W'(r3_db) - DIFF_W'(cfg.floor_q8);
  assign prod_g = (DIFF_W+GAIN_W)'(diff) * (DIFF_W+GAIN_W)'(cfg.gain_q16);
  always_comb begin
    if (!above) begin
      lvl_g = '0;
    end else if (|prod_g[DIFF_W+GAIN_W-1:LEVEL_W+8]) begin
      lvl_g = '1;
    end else begin
      lvl_g = prod_g[LEVEL_W+7:8];
    end
  end

  assign att_on = (ATT_ON != 0) && (r4_band >= BAND_W'(ATTEN_START));
  assign att_d  = att_on ? (r4_band - BAND_W'(ATTEN_START)) : '0;

  assign prod_r = (PA_W+RECIP_W)'(r5_prod) * (PA_W+RECIP_W)'(RECIP);
  assign drop   = prod_r[PA_W+RECIP_W-1:RECIP_SH];
  assign fac    = (|drop[$bits(drop)-1:LEVEL_W]) ? '0
                                                 : FAC_ONE - FAC_W'(drop[LEVEL_W-1:0]);

  assign prod_f = (LEVEL_W+FAC_W)'(r6_lvl) * (LEVEL_W+FAC_W)'(r6_fac);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], start};
    end
  end

  always_ff @(posedge clk) begin
    r1_p     <= lead;
    r1_mag   <= mag;
    r1_small <= ~|mag[MAG_WIDTH-1:8];
    r1_band  <= band;

    r2_l2    <= l2;
    r2_small <= r1_small;
    r2_band  <= r1_band;

    r3_db    <= prod_db[L2_W+10:8];
    r3_small <= r2_small;
    r3_band  <= r2_band;

    r4_lvl   <= lvl_g;
    r4_band  <= r3_band;

    r5_prod  <= PA_W'(cfg.depth_q16) * PA_W'(att_d);
    r5_lvl   <= r4_lvl;

    r6_fac   <= fac;
    r6_lvl   <= r5_lvl;

    level    <= prod_f[2*LEVEL_W-1:LEVEL_W];
  end

  assign done = vld[6];

endmodule

[rtl/core/spectrum_band_level_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_level_meter
// Groups FFT magnitude bins into bands by a loaded edge table, keeps each
// band's peak and emits a smoothed dB level per band when it closes.
// ----------------------------------------------------------------------------
// an edge load is taken in the idle state; a bin that closes no band reads
//   the edge table three times (upper, lower, upper edge) through its single read port
// each closed band adds the 7-stage level pipeline, smoothing read-modify-write and
//   result load, then an edge re-read outside the frame-end flush
// reset clears registers, frame state and smoothed-level valid bits; the
//   edge table holds no reset value and must be loaded before bins arrive
module spectrum_band_level_meter import sblm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  sblm_item_if.sink      item,
  sblm_result_if.source  result,
  sblm_cfg_if.sink       cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_HI, S_CMP_HI, S_RD_LO, S_CMP_LO, S_FIN, S_EMIT, S_WAIT, S_PUT
  } state_t;

  state_t state;

  // registers
  logic [FLOOR_W-1:0] floor_q8;
  logic [GAIN_W-1:0]  gain_q16;
  logic [KEEP_W-1:0]  keep_q8;
  logic [DEPTH_W-1:0] depth_q16;

  // frame state
  logic [CNT_W-1:0]     bin_cnt;
  logic [CB_W-1:0]      cur_band;
  logic [MAG_WIDTH-1:0] band_max;

  // item in flight
  logic [MAG_WIDTH-1:0] item_mag;
  logic                 item_last;
  logic [CNT_W-1:0]     item_j;
  logic                 item_live;
  logic                 phase_b;
  logic                 flushing;

  logic [BANDS-1:0]     sm_valid;
  logic                 old_valid;
  logic [SMP_W-1:0]     p_old;
  logic [SMP_W-1:0]     p_new;

  logic                 res_valid;
  logic [BAND_W-1:0]    res_band;
  logic [LEVEL_W-1:0]   res_level;
  logic                 res_last;

  // combinational, plus RAM and level pipeline outputs
  logic                 item_xfer;
  logic                 edge_wr;
  logic                 edge_rd_en;
  logic [EA_W-1:0]      edge_rd_addr;
  logic [EDGE_W-1:0]    edge_rd;
  logic [SM_AW-1:0]     sm_addr;
  logic [LEVEL_W-1:0]   sm_rd;
  logic [CB_W-1:0]      cb_inc;
  logic                 more_bands;
  logic [CNT_W-1:0]     thr;
  logic                 hit_hi;
  logic                 hit_lo;
  logic [KEEP_W-1:0]    keep_sat;
  logic [KEEP_W-1:0]    keep_inv;
  logic [LEVEL_W-1:0]   old_lvl;
  logic [SMP_W-1:0]     sm_sum;
  logic [LEVEL_W-1:0]   new_lvl;
  logic                 put_ok;
  logic                 lvl_done;
  logic [LEVEL_W-1:0]   lvl_out;
  lvl_cfg_t             lvl_cfg;

  assign item_xfer = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign edge_wr = item_xfer && (item.mode == MODE_LOAD)
                   && (item.edge_slot <= SLOT_W'(BANDS));

  assign edge_rd_en   = (state == S_RD_HI) || (state == S_RD_LO);
  assign edge_rd_addr = (state == S_RD_HI) ? EA_W'(cur_band + CB_W'(1)) : EA_W'(cur_band);

  assign sm_addr    = SM_AW'(cur_band);
  assign cb_inc     = cur_band + CB_W'(1);
  assign more_bands = cb_inc < CB_W'(BANDS);

  // after the bin counts, bands ending at j+1 close too
  assign thr    = phase_b ? (item_j + CNT_W'(1)) : item_j;
  assign hit_hi = CMP_W'(thr) >= CMP_W'(edge_rd);
  assign hit_lo = CMP_W'(item_j) >= CMP_W'(edge_rd);

  assign keep_sat = keep_q8[KEEP_W-1] ? KEEP_W'(256) : keep_q8;
  assign keep_inv = KEEP_W'(256) - keep_sat;
  assign old_lvl  = old_valid ? sm_rd : '0;
  assign sm_sum   = p_old + p_new;
  assign new_lvl  = sm_sum[LEVEL_W+7:8];
  assign put_ok   = !res_valid || result.ready;

  assign lvl_cfg.floor_q8  = floor_q8;
  assign lvl_cfg.gain_q16  = gain_q16;
  assign lvl_cfg.depth_q16 = depth_q16;

  sblm_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (BANDS + 1)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_wr),
    .wr_addr (EA_W'(item.edge_slot)),
    .wr_data (item.edge_bin),
    .rd_en   (edge_rd_en),
    .rd_addr (edge_rd_addr),
    .rd_data (edge_rd)
  );

  sblm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (BANDS)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   ((state == S_PUT) && put_ok),
    .wr_addr (sm_addr),
    .wr_data (new_lvl),
    .rd_en   (state == S_EMIT),
    .rd_addr (sm_addr),
    .rd_data (sm_rd)
  );

  sblm_level u_level (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EMIT),
    .mag   (band_max),
    .band  (BAND_W'(cur_band)),
    .cfg   (lvl_cfg),
    .done  (lvl_done),
    .level (lvl_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_q8  <= FLOOR_RST;
      gain_q16  <= GAIN_RST;
      keep_q8   <= KEEP_RST;
      depth_q16 <= DEPTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FLOOR: floor_q8  <= cfg.data[FLOOR_W-1:0];
        CFG_GAIN:  gain_q16  <= cfg.data[GAIN_W-1:0];
        CFG_KEEP:  keep_q8   <= cfg.data[KEEP_W-1:0];
        CFG_DEPTH: depth_q16 <= cfg.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_cnt   <= '0;
      cur_band  <= '0;
      band_max  <= '0;
      phase_b   <= 1'b0;
      flushing  <= 1'b0;
      sm_valid  <= '0;
      res_valid <= 1'b0;
    end else begin
      // a put in the same cycle reloads the result register
      if (res_valid && result.ready && (state != S_PUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid && (item.mode == MODE_BIN)) begin
            item_mag  <= item.magnitude;
            item_last <= item.last_bin;
            item_j    <= bin_cnt;
            item_live <= bin_cnt < CNT_W'(FFT_BINS);
            phase_b   <= 1'b0;
            if ((bin_cnt < CNT_W'(FFT_BINS)) && (cur_band < CB_W'(BANDS))) begin
              state <= S_RD_HI;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RD_HI: state <= S_CMP_HI;
        S_CMP_HI: begin
          if (hit_hi) begin
            state <= S_EMIT;
          end else if (!phase_b) begin
            state <= S_RD_LO;
          end else begin
            state <= S_FIN;
          end
        end
        S_RD_LO: state <= S_CMP_LO;
        S_CMP_LO: begin
          if (hit_lo && (item_mag > band_max)) begin
            band_max <= item_mag;
          end
          phase_b <= 1'b1;
          state   <= S_RD_HI;
        end
        S_FIN: begin
          if (!item_last) begin
            if (item_live) begin
              bin_cnt <= item_j + CNT_W'(1);
            end
            state <= S_IDLE;
          end else if (cur_band < CB_W'(BANDS)) begin
            // counter returns to zero once the flush ends
            flushing <= 1'b1;
            state    <= S_EMIT;
          end else begin
            bin_cnt  <= '0;
            cur_band <= '0;
            band_max <= '0;
            state    <= S_IDLE;
          end
        end
        S_EMIT: begin
          old_valid <= sm_valid[sm_addr];
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (lvl_done) begin
            p_old <= SMP_W'(keep_sat) * SMP_W'(old_lvl);
            p_new <= SMP_W'(keep_inv) * SMP_W'(lvl_out);
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_ok) begin
            res_valid         <= 1'b1;
            res_band          <= BAND_W'(cur_band);
            res_level         <= new_lvl;
            res_last          <= (cur_band == CB_W'(BANDS - 1));
            sm_valid[sm_addr] <= 1'b1;
            band_max          <= '0;
            if (flushing && !more_bands) begin
              // frame done: back to the first bin and band
              flushing <= 1'b0;
              bin_cnt  <= '0;
              cur_band <= '0;
              state    <= S_IDLE;
            end else begin
              cur_band <= cb_inc;
              if (flushing) begin
                state <= S_EMIT;
              end else if (more_bands) begin
                state <= S_RD_HI;
              end else begin
                state <= S_FIN;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid     = res_valid;
  assign result.band      = res_band;
  assign result.level     = res_level;
  assign result.last_band = res_last;

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    cur_band <= CB_W'(BANDS))
    else $error("band index past last band");

  a_bin_sat: assert property (@(posedge clk) disable iff (rst)
    bin_cnt <= CNT_W'(FFT_BINS))
    else $error("bin counter past saturation");

  a_level_done: assert property (@(posedge clk) disable iff (rst)
    lvl_done |-> (state == S_WAIT))
    else $error("level pipeline finished outside wait");

  a_put: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PUT) && put_ok) |=> (res_valid && (band_max == '0)))
    else $error("band close did not load result or clear peak");

  a_bin_busy: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && (item.mode == MODE_BIN)) |=> (state != S_IDLE))
    else $error("bin transfer left the sequencer idle");

endmodule
